FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, codes and helpers for the infix to prefix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int MAX_LEN_DEF = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_UNBAL = 2'd2;

  // operator stack command
  typedef struct packed {
    logic       seed;  // restart stack holding data only
    logic       push;
    logic       pop;
    logic [7:0] data;
  } stk_cmd_t;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) || (c == CH_DIV);
  endfunction

  function automatic logic is_paren(input logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

  // true when top-of-stack operator must be output before cur is pushed
  function automatic logic binds_tighter(input logic [7:0] top, input logic [7:0] cur);
    return ((top == CH_MUL) || (top == CH_DIV)) && ((cur == CH_PLUS) || (cur == CH_MINUS));
  endfunction

endpackage

FILE: rtl/itp_buf.sv
// ----------------------------------------------------------------------------
// itp_buf
// Character memory: lower half holds the infix text, upper half the prefix
// text. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module itp_buf import itp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_LEN):0]     waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [$clog2(MAX_LEN):0]     raddr,
  output logic [7:0]                   rdata
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int DEPTH = 2 ** (AW + 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack. Top entry cached in a register, the rest in a memory.
// A pop reloads the top through a read register; the caller waits for it.
// ----------------------------------------------------------------------------
module itp_stack import itp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  stk_cmd_t   cmd,
  output logic [7:0] top
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = $clog2(MAX_LEN + 2);

  logic [7:0]    mem [MAX_LEN];
  logic [SW-1:0] sp_r, sp_nxt;
  logic [7:0]    top_r, top_nxt;
  logic [7:0]    rd_r;
  logic          refill_r;
  logic [SW-1:0] sp_m1, sp_m2;
  logic          full;

  assign sp_m1 = sp_r - 1'b1;
  assign sp_m2 = sp_r - SW'(2);
  assign full  = (sp_r == SW'(MAX_LEN + 1));

  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    if (refill_r) begin
      top_nxt = rd_r;
    end
    if (cmd.seed) begin
      sp_nxt  = SW'(1);
      top_nxt = cmd.data;
    end else if (cmd.push && !full) begin
      sp_nxt  = sp_r + 1'b1;
      top_nxt = cmd.data;
    end else if (cmd.pop && (sp_r != '0)) begin
      sp_nxt  = sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r     <= '0;
      refill_r <= 1'b0;
    end else begin
      sp_r     <= sp_nxt;
      refill_r <= cmd.pop && !cmd.seed;
    end
    top_r <= top_nxt;
  end

  // memory: spill old top on push, fetch next-below on pop
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.seed && !full && (sp_r != '0)) begin
      mem[sp_m1[AW-1:0]] <= top_r;
    end
    if (cmd.pop) begin
      rd_r <= mem[sp_m2[AW-1:0]];
    end
  end

  assign top = top_r;

endmodule

FILE: rtl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: loads the text, runs the reversed scan against the stack, then
// streams the prefix text through the output register, or one status word.
// ----------------------------------------------------------------------------
module itp_ctrl import itp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_char,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_char,
  output logic                     out_last,
  output logic [1:0]               out_status,
  output logic                     buf_we,
  output logic [$clog2(MAX_LEN):0] buf_waddr,
  output logic [7:0]               buf_wdata,
  output logic                     buf_re,
  output logic [$clog2(MAX_LEN):0] buf_raddr,
  input  logic [7:0]               buf_rdata,
  output stk_cmd_t                 stk_cmd,
  input  logic [7:0]               stk_top
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_LAT = 4'd2;
  localparam logic [3:0] S_EXEC     = 4'd3;
  localparam logic [3:0] S_REFILL   = 4'd4;
  localparam logic [3:0] S_EMIT_RD  = 4'd5;
  localparam logic [3:0] S_EMIT_WR  = 4'd6;
  localparam logic [3:0] S_SINGLE   = 4'd7;

  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, depth_r, depth_nxt, nonp_r, nonp_nxt;
  logic [CW-1:0] idx_r, idx_nxt, pos_r, pos_nxt, n_r, n_nxt, k_r, k_nxt;
  logic          ovf_r, ovf_nxt, bad_r, bad_nxt, fin_r, fin_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    oc_r, oc_nxt;
  logic          ol_r, ol_nxt;
  logic [1:0]    os_r, os_nxt;

  logic          acc, stored, out_free;
  logic          ovf_n, bad_n;
  logic [CW-1:0] cnt_n, depth_n, nonp_n;
  logic [CW-1:0] pos_m1, idx_m1, k_p1;

  assign acc      = in_valid && (state_r == S_LOAD);
  assign in_stall = (state_r != S_LOAD);
  assign out_free = !ov_r || !out_stall;
  assign stored   = (cnt_r < CW'(MAX_LEN));
  assign pos_m1   = pos_r - 1'b1;
  assign idx_m1   = idx_r - 1'b1;
  assign k_p1     = k_r + 1'b1;

  // running counts including the word now offered
  always_comb begin
    cnt_n   = cnt_r;
    depth_n = depth_r;
    nonp_n  = nonp_r;
    bad_n   = bad_r;
    ovf_n   = ovf_r || !stored;
    if (stored) begin
      cnt_n = cnt_r + 1'b1;
      if (in_char == CH_LPAR) begin
        depth_n = depth_r + 1'b1;
      end else if (in_char == CH_RPAR) begin
        if (depth_r == '0) begin
          bad_n = 1'b1;
        end else begin
          depth_n = depth_r - 1'b1;
        end
      end else begin
        nonp_n = nonp_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    depth_nxt = depth_r;
    nonp_nxt  = nonp_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    fin_nxt   = fin_r;
    cur_nxt   = cur_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && out_stall;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    os_nxt    = os_r;
    buf_we    = 1'b0;
    buf_waddr = '0;
    buf_wdata = in_char;
    buf_re    = 1'b0;
    buf_raddr = '0;
    stk_cmd   = '{seed: 1'b0, push: 1'b0, pop: 1'b0, data: cur_r};

    case (state_r)
      S_LOAD: begin
        if (acc) begin
          buf_we    = stored;
          buf_waddr = {1'b0, cnt_r[AW-1:0]};
          cnt_nxt   = cnt_n;
          depth_nxt = depth_n;
          nonp_nxt  = nonp_n;
          ovf_nxt   = ovf_n;
          bad_nxt   = bad_n;
          if (in_last) begin
            cnt_nxt   = '0;
            depth_nxt = '0;
            nonp_nxt  = '0;
            ovf_nxt   = 1'b0;
            bad_nxt   = 1'b0;
            if (ovf_n) begin
              stat_nxt  = ST_LONG;
              state_nxt = S_SINGLE;
            end else if (bad_n || (depth_n != '0)) begin
              stat_nxt  = ST_UNBAL;
              state_nxt = S_SINGLE;
            end else if (nonp_n == '0) begin
              stat_nxt  = ST_OK;
              state_nxt = S_SINGLE;
            end else begin
              n_nxt        = nonp_n;
              pos_nxt      = nonp_n;
              idx_nxt      = cnt_n;
              k_nxt        = '0;
              fin_nxt      = 1'b0;
              stk_cmd.seed = 1'b1;
              stk_cmd.data = CH_RPAR;
              state_nxt    = S_SCAN_RD;
            end
          end
        end
      end

      S_SCAN_RD: begin
        if (idx_r == '0) begin
          cur_nxt   = CH_LPAR;  // implicit leading paren
          fin_nxt   = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          buf_re    = 1'b1;
          buf_raddr = {1'b0, idx_m1[AW-1:0]};
          idx_nxt   = idx_m1;
          state_nxt = S_SCAN_LAT;
        end
      end

      S_SCAN_LAT: begin
        cur_nxt   = buf_rdata;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        buf_waddr = {1'b1, pos_m1[AW-1:0]};
        buf_wdata = stk_top;
        if (is_op(cur_r)) begin
          if (binds_tighter(stk_top, cur_r)) begin
            buf_we      = 1'b1;
            pos_nxt     = pos_m1;
            stk_cmd.pop = 1'b1;
            ret_nxt     = S_EXEC;
            state_nxt   = S_REFILL;
          end else begin
            stk_cmd.push = 1'b1;
            state_nxt    = S_SCAN_RD;
          end
        end else if (cur_r == CH_LPAR) begin
          stk_cmd.pop = 1'b1;
          state_nxt   = S_REFILL;
          if (stk_top != CH_RPAR) begin
            buf_we  = 1'b1;
            pos_nxt = pos_m1;
            ret_nxt = S_EXEC;
          end else begin
            ret_nxt = fin_r ? S_EMIT_RD : S_SCAN_RD;
          end
        end else if (cur_r == CH_RPAR) begin
          stk_cmd.push = 1'b1;
          state_nxt    = S_SCAN_RD;
        end else begin
          buf_we    = 1'b1;
          buf_wdata = cur_r;
          pos_nxt   = pos_m1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_REFILL: begin
        state_nxt = ret_r;
      end

      S_EMIT_RD: begin
        if (out_free) begin
          buf_re    = 1'b1;
          buf_raddr = {1'b1, k_r[AW-1:0]};
          state_nxt = S_EMIT_WR;
        end
      end

      S_EMIT_WR: begin
        ov_nxt = 1'b1;
        oc_nxt = buf_rdata;
        ol_nxt = (k_p1 == n_r);
        os_nxt = ST_OK;
        k_nxt  = k_p1;
        state_nxt = (k_p1 == n_r) ? S_LOAD : S_EMIT_RD;
      end

      S_SINGLE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = CH_NUL;
          ol_nxt    = 1'b1;
          os_nxt    = stat_r;
          state_nxt = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      depth_r <= '0;
      nonp_r  <= '0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      depth_r <= depth_nxt;
      nonp_r  <= nonp_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
      ov_r    <= ov_nxt;
    end
    ret_r  <= ret_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    fin_r  <= fin_nxt;
    cur_r  <= cur_nxt;
    stat_r <= stat_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
    os_r   <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_char   = oc_r;
  assign out_last   = ol_r;
  assign out_status = os_r;

endmodule

FILE: rtl/infix_to_prefix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_prefix_converter
// Collects an infix expression and streams it back in prefix form.
// ----------------------------------------------------------------------------
// Send the expression one character per input word, in_last on the final
// one. Each non-final word is taken and produces nothing. On the final
// word the block stops taking input and converts. The stored text is
// scanned from its end through one character memory. Each character takes
// a read, a read-latency state and an execute step. The implicit leading
// paren adds a scan state and an execute step. Every operator popped from
// the stack adds an execute step plus a top-of-stack reload from the stack
// memory; the closing paren that a '(' removes adds only the reload.
// The prefix text is then streamed out with one memory read plus the output
// register load per character. The one character memory and the stack
// reload set the pace; output stalls slow it further. Operators are + - * /,
// with * and / binding tighter; every other byte is an operand. Parentheses
// are dropped from the result. A text longer than MAX_LEN gives one word
// with out_status 1, unbalanced parentheses one word with out_status 2 (too
// long wins), and a text of only parentheses one word with out_char 0 and
// out_status 0. The last result word carries out_last. Input is taken again
// once the last result word is loaded into the output register, even if it
// is still stalled.
// ----------------------------------------------------------------------------
module infix_to_prefix_converter import itp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic [1:0] out_status
);

  localparam int AW = $clog2(MAX_LEN);

  logic          buf_we, buf_re;
  logic [AW:0]   buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;
  stk_cmd_t      stk_cmd;
  logic [7:0]    stk_top;

  // infix text in the lower half, prefix text in the upper half
  itp_buf #(.MAX_LEN(MAX_LEN)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // operator stack, seeded with a closing paren at conversion start
  itp_stack #(.MAX_LEN(MAX_LEN)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .top   (stk_top)
  );

  itp_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last),
    .out_status (out_status),
    .buf_we     (buf_we),
    .buf_waddr  (buf_waddr),
    .buf_wdata  (buf_wdata),
    .buf_re     (buf_re),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .stk_cmd    (stk_cmd),
    .stk_top    (stk_top)
  );

endmodule

FILE: rtl/itp_chk.sv
// ----------------------------------------------------------------------------
// itp_chk
// Port-level checks for the infix to prefix converter.
// ----------------------------------------------------------------------------
module itp_chk import itp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic [1:0] out_status
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output word changed");

  // error words are single and blank
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_char == CH_NUL) && out_last)
    else $error("error word not blank or not last");

  // a non-final input word never starts a conversion
  a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last |=> !in_stall)
    else $error("input blocked after a non-final word");

  // a final input word always blocks input for conversion
  a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken right after a final word");

endmodule

bind infix_to_prefix_converter itp_chk u_itp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_last    (in_last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_char   (out_char),
  .out_last   (out_last),
  .out_status (out_status)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix to prefix converter.
//
// Infix text goes in one word per character. On the last word the bench
// works out the prefix text itself and queues the words that should come
// out. Every accepted out word is checked field by field against the oldest
// queued word. A short directed list comes first: lone extreme bytes, only
// parentheses, both kinds of unbalanced text, and every operator. Random
// expressions follow, most of them balanced, the rest broken, noisy, too
// long, or right at the buffer size. Both sides idle at random. The receiver
// also holds off once for a long stretch, and the sender waits three times
// until every queued word has come out.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import itp_pkg::*;

  localparam int MAX_LEN      = MAX_LEN_DEF;
  localparam int TOTAL_WORDS  = 420;   // input words, directed part included
  localparam int HOLD_CYCLES  = 400;   // the one long receiver hold-off
  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 200;   // quiet time after the last out word
  localparam int SHOW_LIMIT   = 40;    // mismatch lines printed at most

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] status;
  } prefix_word_t;

  // One row of the directed list. When typed is set, the out word is given
  // here. Otherwise the prefix predictor supplies it.
  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    prefix_word_t want;
  } plan_row_t;

  localparam prefix_word_t NONE = '0;

  localparam plan_row_t DIRECTED [23] = '{
    // lone NUL and lone 8'hFF are plain operands
    '{CH_NUL,   1'b1, 1'b1, '{CH_NUL, 1'b1, ST_OK}},
    '{8'hFF,    1'b1, 1'b1, '{8'hFF,  1'b1, ST_OK}},
    // only parentheses: one empty word
    '{CH_LPAR,  1'b0, 1'b0, NONE},
    '{CH_RPAR,  1'b1, 1'b1, '{CH_NUL, 1'b1, ST_OK}},
    // closes before it opens
    '{CH_RPAR,  1'b0, 1'b0, NONE},
    '{CH_LPAR,  1'b1, 1'b1, '{CH_NUL, 1'b1, ST_UNBAL}},
    // never closed
    '{CH_LPAR,  1'b1, 1'b1, '{CH_NUL, 1'b1, ST_UNBAL}},
    // a+b*c-d/e : all four operators, mixed precedence
    '{"a",      1'b0, 1'b0, NONE},
    '{CH_PLUS,  1'b0, 1'b0, NONE},
    '{"b",      1'b0, 1'b0, NONE},
    '{CH_MUL,   1'b0, 1'b0, NONE},
    '{"c",      1'b0, 1'b0, NONE},
    '{CH_MINUS, 1'b0, 1'b0, NONE},
    '{"d",      1'b0, 1'b0, NONE},
    '{CH_DIV,   1'b0, 1'b0, NONE},
    '{"e",      1'b1, 1'b0, NONE},
    // (a-b)*c : a parenthesized group
    '{CH_LPAR,  1'b0, 1'b0, NONE},
    '{"a",      1'b0, 1'b0, NONE},
    '{CH_MINUS, 1'b0, 1'b0, NONE},
    '{"b",      1'b0, 1'b0, NONE},
    '{CH_RPAR,  1'b0, 1'b0, NONE},
    '{CH_MUL,   1'b0, 1'b0, NONE},
    '{"c",      1'b1, 1'b0, NONE}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_char   = '0;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] out_status;

  infix_to_prefix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last),
    .out_status (out_status)
  );

  always #5ns clk = ~clk;

  // --------------------------------------------------------------------------
  // Prefix predictor: the bench's own copy of the text, the operator stack
  // and the prefix text.
  // --------------------------------------------------------------------------
  logic [7:0]   infix_text [MAX_LEN];
  int           infix_len      = 0;
  bit           infix_too_long = 1'b0;
  logic [7:0]   op_stack [MAX_LEN+1];
  int           op_depth       = 0;
  logic [7:0]   prefix_text [MAX_LEN];
  int           fill_pos       = 0;
  prefix_word_t prefix_words[$];  // out words of the latest conversion
  prefix_word_t prefix_due[$];    // out words still to come, oldest first

  int  errors        = 0;
  int  words_in      = 0;
  int  burst_left    = 1;
  bit  long_hold_req = 1'b0;

  // 2 for * and /, 1 for + and -, 0 for everything else
  function automatic int op_rank(logic [7:0] c);
    case (c)
      CH_MUL, CH_DIV:    return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:           return 0;
    endcase
  endfunction

  function automatic void stack_push(logic [7:0] c);
    if (op_depth < MAX_LEN + 1) begin
      op_stack[op_depth] = c;
      op_depth++;
    end
  endfunction

  // the prefix text is filled from its right end
  function automatic void emit_right(logic [7:0] c);
    if (fill_pos > 0) begin
      fill_pos--;
      prefix_text[fill_pos] = c;
    end
  endfunction

  function automatic void to_prefix(logic [7:0] c, logic last);
    int         depth;
    int         n;
    bit         bad;
    logic [7:0] cur;
    logic [7:0] top;
    prefix_words.delete();
    if (infix_len < MAX_LEN) begin
      infix_text[infix_len] = c;
      infix_len++;
    end else begin
      infix_too_long = 1'b1;
    end
    if (!last) return;

    // paren depth left to right, and the count of non-paren characters
    depth = 0;
    n     = 0;
    bad   = 1'b0;
    for (int i = 0; i < infix_len; i++) begin
      if (infix_text[i] == CH_LPAR) begin
        depth++;
      end else if (infix_text[i] == CH_RPAR) begin
        depth--;
        if (depth < 0) bad = 1'b1;
      end else begin
        n++;
      end
    end
    if (depth != 0) bad = 1'b1;

    if (infix_too_long) begin
      prefix_words.push_back(prefix_word_t'{CH_NUL, 1'b1, ST_LONG});
    end else if (bad) begin
      prefix_words.push_back(prefix_word_t'{CH_NUL, 1'b1, ST_UNBAL});
    end else begin
      fill_pos = n;
      op_depth = 0;
      stack_push(CH_RPAR);
      // scan from the end back to an implied leading '('
      for (int j = infix_len; j >= 0; j--) begin
        cur = (j == 0) ? CH_LPAR : infix_text[j-1];
        if (op_rank(cur) != 0) begin
          // only * or / on top of an incoming + or - gets popped
          while (op_depth > 0) begin
            top = op_stack[op_depth-1];
            if (op_rank(top) == 2 && op_rank(cur) == 1) begin
              op_depth--;
              emit_right(top);
            end else begin
              break;
            end
          end
          stack_push(cur);
        end else if (cur == CH_LPAR) begin
          while (op_depth > 0) begin
            op_depth--;
            if (op_stack[op_depth] == CH_RPAR) break;
            emit_right(op_stack[op_depth]);
          end
        end else if (cur == CH_RPAR) begin
          stack_push(cur);
        end else begin
          emit_right(cur);
        end
      end
      if (n == 0) begin
        prefix_words.push_back(prefix_word_t'{CH_NUL, 1'b1, ST_OK});
      end else begin
        for (int k = 0; k < n; k++)
          prefix_words.push_back(prefix_word_t'{prefix_text[k], k == n - 1, ST_OK});
      end
    end
    infix_len      = 0;
    infix_too_long = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. A word is driven at a clock edge and stays put until the
  // edge where in_stall is low. It is predicted right there. Bursts of random
  // length end in a random gap. About a quarter of them run straight into the
  // next burst, so there are long stretches with no idling.
  // --------------------------------------------------------------------------
  task automatic put_word(logic [7:0] c, logic last, logic typed = 1'b0,
                          prefix_word_t want = NONE);
    int gap;
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    to_prefix(c, last);
    if (typed)
      prefix_due.push_back(want);
    else
      foreach (prefix_words[k]) prefix_due.push_back(prefix_words[k]);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, then wait until every queued out word has arrived.
  task automatic drain_prefix_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (prefix_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random expression builders. The text goes into infix_q.
  // --------------------------------------------------------------------------
  logic [7:0] infix_q[$];

  function automatic logic [7:0] any_operand();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'($urandom_range(8'h61, 8'h7A));
      1: c = 8'($urandom_range(8'h30, 8'h39));
      2: c = 8'($urandom_range(8'h41, 8'h5A));
      default: begin
        // any byte that is neither an operator nor a paren, NUL and 8'hFF too
        c = 8'($urandom_range(0, 255));
        while (op_rank(c) != 0 || c == CH_LPAR || c == CH_RPAR)
          c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // operands joined by operators, with nested groups up to three deep
  function automatic void build_balanced();
    int terms;
    int depth;
    infix_q.delete();
    terms = $urandom_range(1, 8);
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      while (depth < 3 && infix_q.size() < 20 && $urandom_range(0, 3) == 0) begin
        infix_q.push_back(CH_LPAR);
        depth++;
      end
      infix_q.push_back(any_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        infix_q.push_back(CH_RPAR);
        depth--;
      end
      if (t < terms - 1) infix_q.push_back(any_operator());
    end
    repeat (depth) infix_q.push_back(CH_RPAR);
  endfunction

  // operand, operator, operand ... of a given length, without parens
  function automatic void build_chain(int len);
    infix_q.delete();
    for (int i = 0; i < len; i++)
      infix_q.push_back((i % 2 == 0) ? any_operand() : any_operator());
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic note_error(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (errors <= SHOW_LIMIT)
      $display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Out side check: every accepted word against the oldest queued word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    prefix_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (prefix_due.size() == 0) begin
        note_error("out word with none queued", out_char, CH_NUL);
      end else begin
        want = prefix_due.pop_front();
        if (out_char !== want.ch)
          note_error("out_char", out_char, want.ch);
        if (out_last !== want.last)
          note_error("out_last", 8'(out_last), 8'(want.last));
        if (out_status !== want.status)
          note_error("out_status", 8'(out_status), 8'(want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver side. out_stall follows a 16-bit pattern that is replaced now
  // and then: no stall, random, sparse or heavy. On request it holds off for
  // HOLD_CYCLES in one go, so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    logic [15:0] stall_pat;
    int          pat_pos;
    int          pat_runs;
    stall_pat = '0;
    pat_pos   = 0;
    pat_runs  = 4;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= stall_pat[pat_pos];
      pat_pos++;
      if (pat_pos == 16) begin
        pat_pos = 0;
        pat_runs--;
        if (pat_runs == 0) begin
          pat_runs = $urandom_range(1, 8);
          case ($urandom_range(0, 3))
            0:       stall_pat = '0;
            1:       stall_pat = 16'($urandom);
            2:       stall_pat = 16'($urandom & $urandom);
            default: stall_pat = 16'($urandom | $urandom);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when its quiet counter reaches IDLE_LIMIT; the
  // counter restarts on any handshake on either side. The longest quiet
  // stretch in a good run is the long hold-off plus the conversion of a full
  // buffer, well under the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    int len;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    burst_left = $urandom_range(1, 24);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r])
      put_word(DIRECTED[r].ch, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);

    // sender pause: everything from the directed part comes out first
    drain_prefix_words();

    while (words_in < TOTAL_WORDS) begin
      // one long hold-off on the out side while words keep coming in
      if (!hold_done && words_in >= 180) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!pause_done && words_in >= 300) begin
        drain_prefix_words();
        pause_done = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_balanced();
      end else if (pick < 72) begin
        // one stray paren anywhere makes the text unbalanced
        build_balanced();
        infix_q.insert($urandom_range(0, infix_q.size()),
                       $urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
      end else if (pick < 86) begin
        // noise: raw bytes, half of them operators or parens
        infix_q.delete();
        len = $urandom_range(1, 34);
        repeat (len) begin
          if ($urandom_range(0, 1))
            infix_q.push_back(8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 2) == 0)
            infix_q.push_back($urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
          else
            infix_q.push_back(any_operator());
        end
      end else if (pick < 93) begin
        build_chain($urandom_range(MAX_LEN + 1, MAX_LEN + 8));  // too long
      end else begin
        build_chain($urandom_range(MAX_LEN - 1, MAX_LEN + 1));  // at the edge
      end

      foreach (infix_q[i]) put_word(infix_q[i], i == infix_q.size() - 1);
    end

    drain_prefix_words();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
